@@ rtl/pklpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pklpm_pkg
// Types and fixed constants of the pair-keyed linear probe map.
// ----------------------------------------------------------------------------
package pklpm_pkg;

  localparam int ID_FIELD_W = 16;
  localparam int ORD_W      = 8;
  localparam int OFF_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int VAL_W      = ORD_W + OFF_W;

  // hash mix
  localparam int          HASH_W    = 64;
  localparam int          MIX_SHIFT = 29;
  localparam logic [31:0] MUL_K_LO  = 32'h7F4A7C15;
  localparam logic [31:0] MUL_K_HI  = 32'h9E3779B9;

  // load limit as a fraction of the slot count
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd4;

  typedef struct packed {
    logic                  mode;
    logic [ID_FIELD_W-1:0] derived_id;
    logic [ID_FIELD_W-1:0] base_id;
    logic [ORD_W-1:0]      ordinal_in;
    logic [OFF_W-1:0]      offset_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ORD_W-1:0]    ordinal_out;
    logic [OFF_W-1:0]    offset_out;
  } out_item_t;

endpackage

@@ rtl/pklpm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pklpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pklpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/pair_key_linear_probe_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_key_linear_probe_map
// Open-addressing map keyed on (derived, base) with linear probing from a
// hashed start slot; insert/update and lookup, refused above 7/10 load.
// ----------------------------------------------------------------------------
//  channel  | ports                 | handshake
//  ---------+-----------------------+------------------------------------
//  request  | start, busy, in_data  | taken when start high and busy low
//  result   | out_valid, out_data   | one-cycle strobe, cannot be held off
//
// sequence: accept, then the hash states S_H0 to S_H3 on the shared 32x32
//   multiplier, then the remainder steps of S_MOD on the same multiplier when
//   TABLE_SLOTS is not a power of two, then S_RD and S_CMP for each slot probed
//   (key/value RAM registered read).
// the result strobes the cycle after the last compare; busy is low then.
// after reset the key RAM is cleared, one slot a cycle, with busy high.
// the result side has no stall; a new item may start as a result leaves.
// ----------------------------------------------------------------------------
module pair_key_linear_probe_map #(
  parameter int TABLE_SLOTS = 64,
  parameter int ID_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pklpm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output pklpm_pkg::out_item_t out_data
);

  import pklpm_pkg::*;

  localparam int  SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int  PCNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int  MAX_ENTRIES = TABLE_SLOTS * LOAD_NUM / LOAD_DEN;
  localparam int  CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int  KEY_W       = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int  KRAM_W      = 2 * KEY_W + 1;
  localparam bit  IS_POW2     = ((1 << SLOT_W) == TABLE_SLOTS);

  // residues of the 16-bit chunk weights and the reciprocal of the slot count
  localparam logic [31:0] RED_W1  = 32'((64'd1 << 16) % 64'(TABLE_SLOTS));
  localparam logic [31:0] RED_W2  = 32'((64'd1 << 32) % 64'(TABLE_SLOTS));
  localparam logic [31:0] RED_W3  = 32'((64'd1 << 48) % 64'(TABLE_SLOTS));
  localparam logic [31:0] RED_RCP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
  localparam logic [31:0] SLOTS_K = 32'(TABLE_SLOTS);

  // remainder sequencer steps
  localparam logic [2:0] RS_MUL_A = 3'd0;
  localparam logic [2:0] RS_MUL_B = 3'd1;
  localparam logic [2:0] RS_MUL_C = 3'd2;
  localparam logic [2:0] RS_SUM   = 3'd3;
  localparam logic [2:0] RS_RCP   = 3'd4;
  localparam logic [2:0] RS_QM    = 3'd5;
  localparam logic [2:0] RS_FIX   = 3'd6;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_H0   = 9'b000000100,
    S_H1   = 9'b000001000,
    S_H2   = 9'b000010000,
    S_H3   = 9'b000100000,
    S_MOD  = 9'b001000000,
    S_RD   = 9'b010000000,
    S_CMP  = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [PCNT_W-1:0]     prb_cnt_r, prb_cnt_nxt;
  logic [CNT_W-1:0]      entry_cnt_r, entry_cnt_nxt;
  logic [2:0]            red_step_r, red_step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  mode_r, mode_nxt;
  logic [2*KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [HASH_W-1:0]     x_r, x_nxt;
  logic [HASH_W-1:0]     fold_r, fold_nxt;
  logic [31:0]           lo_r, lo_nxt;
  logic [31:0]           hi_r, hi_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [63:0]           prod_r;

  logic [31:0]           mul_a, mul_b;
  logic [HASH_W-1:0]     x_raw;
  logic [31:0]           hi_fin;
  logic [31:0]           fold_lo;
  logic [31:0]           rem_raw;
  logic [31:0]           rem_fit;

  logic                  kram_we;
  logic [KRAM_W-1:0]     kram_wdata;
  logic [KRAM_W-1:0]     kram_rdata;
  logic                  vram_we;
  logic [VAL_W-1:0]      vram_rdata;
  logic                  slot_used;
  logic                  key_match;

  // shared multiplier operands, product registered before any use
  always_comb begin
    mul_a = x_r[31:0];
    mul_b = MUL_K_LO;
    case (state_r)
      S_H1: begin
        mul_b = MUL_K_HI;
      end
      S_H2: begin
        mul_a = x_r[63:32];
      end
      S_MOD: begin
        case (red_step_r)
          RS_MUL_A: begin
            mul_a = 32'(fold_r[63:48]);
            mul_b = RED_W3;
          end
          RS_MUL_B: begin
            mul_a = 32'(fold_r[47:32]);
            mul_b = RED_W2;
          end
          RS_MUL_C: begin
            mul_a = 32'(fold_r[31:16]);
            mul_b = RED_W1;
          end
          RS_RCP: begin
            mul_a = acc_r;
            mul_b = RED_RCP;
          end
          RS_QM: begin
            mul_a = prod_r[63:32];
            mul_b = SLOTS_K;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign x_raw = (HASH_W'(in_data.derived_id[KEY_W-1:0]) << ID_BITS)
               | HASH_W'(in_data.base_id[KEY_W-1:0]);

  assign hi_fin  = hi_r + prod_r[31:0];
  assign fold_lo = lo_r ^ hi_fin;

  // weighted chunk sum less the reciprocal quotient times the slot count,
  // which undershoots by at most one slot count
  assign rem_raw = acc_r - prod_r[31:0];
  assign rem_fit = (rem_raw >= SLOTS_K) ? rem_raw - SLOTS_K : rem_raw;

  assign slot_used = kram_rdata[2*KEY_W];
  assign key_match = (kram_rdata[2*KEY_W-1:0] == key_r);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    prb_cnt_nxt   = prb_cnt_r;
    entry_cnt_nxt = entry_cnt_r;
    red_step_nxt  = red_step_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    x_nxt         = x_r;
    fold_nxt      = fold_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    kram_we       = 1'b0;
    kram_wdata    = {1'b1, key_r};
    vram_we       = 1'b0;

    case (state_r)
      S_CLR: begin
        kram_we    = 1'b1;
        kram_wdata = '0;
        if (slot_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          slot_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_data.mode;
          key_nxt   = {in_data.derived_id[KEY_W-1:0], in_data.base_id[KEY_W-1:0]};
          val_nxt   = {in_data.ordinal_in, in_data.offset_in};
          x_nxt     = x_raw ^ (x_raw >> MIX_SHIFT);
          state_nxt = S_H0;
        end
      end
      S_H0: begin
        state_nxt = S_H1;
      end
      S_H1: begin
        lo_nxt    = prod_r[31:0];
        hi_nxt    = prod_r[63:32];
        state_nxt = S_H2;
      end
      S_H2: begin
        hi_nxt    = hi_fin;
        state_nxt = S_H3;
      end
      S_H3: begin
        // high word xor-folded onto the low word
        fold_nxt     = {hi_fin, fold_lo};
        prb_cnt_nxt  = '0;
        red_step_nxt = RS_MUL_A;
        if (IS_POW2) begin
          slot_nxt  = fold_lo[SLOT_W-1:0];
          state_nxt = S_RD;
        end else begin
          slot_nxt  = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        red_step_nxt = red_step_r + 1'b1;
        case (red_step_r)
          RS_MUL_B: begin
            acc_nxt = prod_r[31:0] + 32'(fold_r[15:0]);
          end
          RS_MUL_C, RS_SUM: begin
            acc_nxt = acc_r + prod_r[31:0];
          end
          RS_FIX: begin
            slot_nxt  = rem_fit[SLOT_W-1:0];
            state_nxt = S_RD;
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        out_data_nxt = '0;
        if (!slot_used) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (mode_r == MODE_LOOKUP) begin
            out_data_nxt.status = STAT_MISS;
          end else if (entry_cnt_r >= CNT_W'(MAX_ENTRIES)) begin
            out_data_nxt.status = STAT_FULL;
          end else begin
            kram_we             = 1'b1;
            vram_we             = 1'b1;
            entry_cnt_nxt       = entry_cnt_r + 1'b1;
            out_data_nxt.status = STAT_INSERTED;
          end
        end else if (key_match) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (mode_r == MODE_LOOKUP) begin
            out_data_nxt.status      = STAT_HIT;
            out_data_nxt.ordinal_out = vram_rdata[VAL_W-1:OFF_W];
            out_data_nxt.offset_out  = vram_rdata[OFF_W-1:0];
          end else begin
            vram_we             = 1'b1;
            out_data_nxt.status = STAT_UPDATED;
          end
        end else if (prb_cnt_r == PCNT_W'(TABLE_SLOTS - 1)) begin
          // whole table walked without an empty slot
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
          out_data_nxt.status = (mode_r == MODE_LOOKUP) ? STAT_MISS : STAT_FULL;
        end else begin
          prb_cnt_nxt = prb_cnt_r + 1'b1;
          slot_nxt    = (slot_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_r + 1'b1;
          state_nxt   = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      slot_r      <= '0;
      prb_cnt_r   <= '0;
      entry_cnt_r <= '0;
      red_step_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      prb_cnt_r   <= prb_cnt_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      red_step_r  <= red_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    x_r        <= x_nxt;
    fold_r     <= fold_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
  end

  pklpm_ram #(
    .WIDTH (KRAM_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (kram_we),
    .wr_addr (slot_r),
    .wr_data (kram_wdata),
    .rd_addr (slot_r),
    .rd_data (kram_rdata)
  );

  pklpm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SLOTS)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (vram_we),
    .wr_addr (slot_r),
    .wr_data (val_r),
    .rd_addr (slot_r),
    .rd_data (vram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/probe_map_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_map_checker
// Watches the request and result channels of the pair-keyed probe map. It
// keeps its own copy of the slot table, works out the reply to every accepted
// item and compares each result strobe with the oldest reply still owed.
// ----------------------------------------------------------------------------
module probe_map_checker #(
  parameter int TABLE_SLOTS = 64,
  parameter int ID_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  pklpm_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  pklpm_pkg::out_item_t out_data,
  output int unsigned          fails,
  output int unsigned          outstanding
);
  import pklpm_pkg::*;

  logic              slot_used [TABLE_SLOTS];
  logic [31:0]       slot_derived [TABLE_SLOTS];
  logic [31:0]       slot_base [TABLE_SLOTS];
  logic [ORD_W-1:0]  slot_ord [TABLE_SLOTS];
  logic [OFF_W-1:0]  slot_off [TABLE_SLOTS];
  int unsigned       live_entries;
  out_item_t         owed_replies [$];

  function automatic logic [31:0] id_part(logic [ID_FIELD_W-1:0] raw);
    return 32'(raw) & ((32'd1 << ID_BITS) - 32'd1);
  endfunction

  function automatic int unsigned home_slot(logic [31:0] derived, logic [31:0] base);
    logic [63:0] x;
    x = (64'(derived) << ID_BITS) | 64'(base);
    x = x ^ (x >> MIX_SHIFT);
    x = x * {MUL_K_HI, MUL_K_LO};
    x = x ^ (x >> 32);
    return int'(x % 64'(TABLE_SLOTS));
  endfunction

  // runs one request against the local table and returns the reply it earns
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t   reply;
    logic [31:0] derived;
    logic [31:0] base;
    int unsigned s;
    int unsigned hit_at;
    int unsigned free_at;
    logic        hit;
    logic        free_seen;
    derived   = id_part(req.derived_id);
    base      = id_part(req.base_id);
    s         = home_slot(derived, base);
    hit       = 1'b0;
    free_seen = 1'b0;
    hit_at    = 0;
    free_at   = 0;
    reply     = '0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slot_used[s]) begin
        free_seen = 1'b1;
        free_at   = s;
        break;
      end
      if (slot_derived[s] == derived && slot_base[s] == base) begin
        hit    = 1'b1;
        hit_at = s;
        break;
      end
      s = (s + 1 == TABLE_SLOTS) ? 0 : s + 1;
    end
    if (req.mode == MODE_LOOKUP) begin
      if (hit) begin
        reply.status      = STAT_HIT;
        reply.ordinal_out = slot_ord[hit_at];
        reply.offset_out  = slot_off[hit_at];
      end else begin
        reply.status = STAT_MISS;
      end
    end else if (hit) begin
      slot_ord[hit_at] = req.ordinal_in;
      slot_off[hit_at] = req.offset_in;
      reply.status     = STAT_UPDATED;
    end else if ((live_entries + 1) * LOAD_DEN > TABLE_SLOTS * LOAD_NUM || !free_seen) begin
      reply.status = STAT_FULL;
    end else begin
      slot_used[free_at]    = 1'b1;
      slot_derived[free_at] = derived;
      slot_base[free_at]    = base;
      slot_ord[free_at]     = req.ordinal_in;
      slot_off[free_at]     = req.offset_in;
      live_entries++;
      reply.status = STAT_INSERTED;
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
      live_entries = 0;
      owed_replies.delete();
      fails = 0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (owed_replies.size() == 0) begin
          fails++;
          $display("%0t: result with nothing owed, expected none, got status %0d ord %0h off %0h",
                   $time, out_data.status, out_data.ordinal_out, out_data.offset_out);
        end else begin
          want = owed_replies.pop_front();
          if (out_data.status !== want.status) begin
            fails++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.ordinal_out !== want.ordinal_out) begin
            fails++;
            $display("%0t: ordinal mismatch, expected %0h, got %0h",
                     $time, want.ordinal_out, out_data.ordinal_out);
          end
          if (out_data.offset_out !== want.offset_out) begin
            fails++;
            $display("%0t: offset mismatch, expected %0h, got %0h",
                     $time, want.offset_out, out_data.offset_out);
          end
        end
      end
      if (start && !busy) owed_replies.insert(owed_replies.size(), apply_request(in_data));
      outstanding <= owed_replies.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the pair-keyed probe map with a directed opening and then random
// insert and lookup traffic over a key pool that overfills the load limit,
// under several sender idling patterns. The checker beside the block owns
// all comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import pklpm_pkg::*;

  localparam int TABLE_SLOTS   = 64;
  localparam int ID_BITS       = 16;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 358;
  localparam int POOL_KEYS     = 56;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_data = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  int unsigned fails;
  int unsigned outstanding;
  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  logic [ID_FIELD_W-1:0] pool_derived [POOL_KEYS];
  logic [ID_FIELD_W-1:0] pool_base [POOL_KEYS];

  pair_key_linear_probe_map #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  probe_map_checker #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .ID_BITS    (ID_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fails      (fails),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input in_item_t it);
    logic [95:0] spray;
    while ($urandom_range(99) < sender_idle_pct) begin
      spray = {$urandom, $urandom, $urandom};
      start   <= 1'b0;
      in_data <= spray[$bits(in_item_t)-1:0];
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue(input logic mode, input logic [15:0] derived, input logic [15:0] base,
                       input logic [7:0] ord, input logic [31:0] off);
    in_item_t it;
    it.mode       = mode;
    it.derived_id = derived;
    it.base_id    = base;
    it.ordinal_in = ord;
    it.offset_in  = off;
    send_item(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_request(input int unsigned pool_lim);
    in_item_t    it;
    int unsigned k;
    it.mode = ($urandom_range(1) == 0) ? MODE_INSERT : MODE_LOOKUP;
    if ($urandom_range(9) == 0) begin
      it.derived_id = 16'($urandom);
      it.base_id    = 16'($urandom);
    end else begin
      k             = $urandom_range(pool_lim - 1);
      it.derived_id = pool_derived[k];
      it.base_id    = pool_base[k];
    end
    case ($urandom_range(7))
      0: begin
        it.ordinal_in = '0;
        it.offset_in  = '0;
      end
      1: begin
        it.ordinal_in = '1;
        it.offset_in  = '1;
      end
      default: begin
        it.ordinal_in = 8'($urandom);
        it.offset_in  = $urandom;
      end
    endcase
    send_item(it);
  endtask

  initial begin
    int unsigned pool_lim;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_derived[i] = 16'($urandom);
      pool_base[i]    = 16'($urandom);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of keys and values, miss on empty table, hits and updates
    issue(MODE_LOOKUP, 16'h0000, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
    issue(MODE_INSERT, 16'h0000, 16'h0000, 8'h00, 32'h0000_0000);
    issue(MODE_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'h0000, 16'h0000, 8'h12, 32'h3456_789A);
    issue(MODE_LOOKUP, 16'hFFFF, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, 16'h0000, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    issue(MODE_INSERT, 16'hFFFF, 16'h0000, 8'h81, 32'h8000_0001);
    issue(MODE_INSERT, 16'h0000, 16'hFFFF, 8'h7E, 32'h7FFF_FFFE);
    issue(MODE_INSERT, 16'h0000, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, 16'h0000, 16'h0000, 8'h00, 32'h0000_0000);
    issue(MODE_INSERT, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    // rewrite with the same value is still an update
    issue(MODE_INSERT, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'h0000, 16'hFFFF, 8'h00, 32'h0000_0000);
    issue(MODE_INSERT, 16'hAAAA, 16'h5555, 8'hA5, 32'h5A5A_5A5A);
    issue(MODE_INSERT, 16'h5555, 16'hAAAA, 8'h5A, 32'hA5A5_A5A5);
    issue(MODE_LOOKUP, 16'hAAAA, 16'h5555, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'h5555, 16'hAAAA, 8'h00, 32'h0000_0000);
    issue(MODE_LOOKUP, 16'hAAAA, 16'hAAAA, 8'h00, 32'h0000_0000);
    wait_drained();

    // pool grows per phase so the table fills gradually, then stays at the limit
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 75;
        2:       sender_idle_pct = 0;
        default: sender_idle_pct = 37;
      endcase
      pool_lim = (ph == 0) ? 20 : (ph == 1) ? 40 : POOL_KEYS;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(pool_lim);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
